FILE: hw/rtl/wrma_pkg.sv
// ----------------------------------------------------------------------------
// wrma_pkg: shared constants for the wrapped range modular ALU
// Operation codes, error codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package wrma_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 16;
    localparam int CFG_INDEX_WIDTH     = 2;

    // register reset values
    localparam int RANGE_LOW_RESET  = 1;
    localparam int RANGE_HIGH_RESET = 12;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RANGE_HIGH = 2'd1;

    // operation codes
    localparam logic [2:0] MODE_ASSIGN  = 3'd0;
    localparam logic [2:0] MODE_ADD     = 3'd1;
    localparam logic [2:0] MODE_SUB     = 3'd2;
    localparam logic [2:0] MODE_MUL     = 3'd3;
    localparam logic [2:0] MODE_DIV     = 3'd4;
    localparam logic [2:0] MODE_REFLECT = 3'd5;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_DIV_ZERO  = 2'd1;
    localparam logic [1:0] ERR_INEXACT   = 2'd2;
    localparam logic [1:0] ERR_BAD_RANGE = 2'd3;

endpackage

FILE: hw/rtl/wrapped_range_modular_alu.sv
// ----------------------------------------------------------------------------
// wrapped_range_modular_alu: accumulator kept inside [range_low, range_high]
// Sequenced ALU with one shared restoring divider for exact division and
// for the floor modulo that wraps each result into the configured range.
// ----------------------------------------------------------------------------
// Timing: one word at a time. With W = VALUE_WIDTH the divider runs 2W+1
// steps per pass, one quotient bit per clock. Assign, add, subtract,
// multiply and reflect take one divider pass. Exact divide takes two
// passes (the quotient, then the wrap). Words that end in an error
// before any division (bad range, divide by zero) or that use an unused
// mode go from setup straight to done, with no divider pass. The result
// sits in an output register, so the next word can be accepted while the
// previous result is stalled; a finished word waits only if the output
// register is still full and stalled.
// Configuration is taken only while the sequencer is idle.
// ----------------------------------------------------------------------------
module wrapped_range_modular_alu #(
    parameter int VALUE_WIDTH = wrma_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input word channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [2:0]                           mode,
    input  logic signed [VALUE_WIDTH-1:0]        operand,
    input  logic                                 commit,
    // result word channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [VALUE_WIDTH-1:0]        result_value,
    output logic signed [VALUE_WIDTH-1:0]        prior_value,
    output logic [1:0]                           error_code,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wrma_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [VALUE_WIDTH-1:0]               cfg_data
);

    localparam int W      = VALUE_WIDTH;
    localparam int RW     = 2 * W + 1;        // raw result / dividend width
    localparam int STEP_W = $clog2(RW);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_SETUP     = 6'b000010,
        S_WRAP_LOAD = 6'b000100,
        S_DIV       = 6'b001000,
        S_POST      = 6'b010000,
        S_DONE      = 6'b100000
    } state_t;

    // control state
    state_t                    state_reg, state_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      exact_pass_reg, exact_pass_next;
    logic [STEP_W-1:0]         cnt_reg, cnt_next;
    logic signed [W-1:0]       held_reg, held_next;
    logic signed [W-1:0]       range_low_reg, range_low_next;
    logic signed [W-1:0]       range_high_reg, range_high_next;

    // payload / datapath
    logic [2:0]                mode_reg, mode_next;
    logic signed [W-1:0]       operand_reg, operand_next;
    logic                      commit_reg, commit_next;
    logic signed [W-1:0]       prior_reg, prior_next;
    logic signed [RW-1:0]      raw_reg, raw_next;
    logic                      neg_reg, neg_next;
    logic [W:0]                rem_reg, rem_next;
    logic [RW-1:0]             quo_reg, quo_next;
    logic [W:0]                dvs_reg, dvs_next;
    logic signed [W-1:0]       res_reg, res_next;
    logic [1:0]                err_reg, err_next;
    logic                      store_reg, store_next;
    logic signed [W-1:0]       result_value_reg, result_value_next;
    logic signed [W-1:0]       prior_value_reg, prior_value_next;
    logic [1:0]                error_code_reg, error_code_next;

    // combinational helpers
    logic signed [W+1:0]       span;
    logic [W:0]                size;
    logic                      bad_range;
    logic signed [2*W-1:0]     prod;
    logic [RW-1:0]             op_x, prior_x, high_x, low_x, prod_x;
    logic [W:0]                prior_w, op_w, mag_prior, mag_op;
    logic [RW:0]               diff, mag_diff;
    logic [W+1:0]              div_shift;
    logic [W+2:0]              div_trial;
    logic [RW-1:0]             q_x;
    logic [W:0]                fix;
    logic [W+1:0]              wrapped;
    logic                      in_take, out_load;

    // range size, always positive when the range is good
    assign span = {{2{range_high_reg[W-1]}}, range_high_reg}
                - {{2{range_low_reg[W-1]}}, range_low_reg} + (W+2)'(1);
    assign size      = span[W:0];
    assign bad_range = (range_high_reg <= range_low_reg);

    // sign extensions into the raw width
    assign op_x    = {{(RW-W){operand_reg[W-1]}}, operand_reg};
    assign prior_x = {{(RW-W){prior_reg[W-1]}}, prior_reg};
    assign high_x  = {{(RW-W){range_high_reg[W-1]}}, range_high_reg};
    assign low_x   = {{(RW-W){range_low_reg[W-1]}}, range_low_reg};

    // the only multiplier, registered into raw_reg
    assign prod   = prior_reg * operand_reg;
    assign prod_x = {{(RW-2*W){prod[2*W-1]}}, prod};

    // magnitudes for exact division
    assign prior_w   = {prior_reg[W-1], prior_reg};
    assign op_w      = {operand_reg[W-1], operand_reg};
    assign mag_prior = prior_w[W] ? -prior_w : prior_w;
    assign mag_op    = op_w[W] ? -op_w : op_w;

    // offset from range_low, for the wrap pass
    assign diff     = {raw_reg[RW-1], raw_reg} - {low_x[RW-1], low_x};
    assign mag_diff = diff[RW] ? -diff : diff;

    // one restoring divider step
    assign div_shift = {rem_reg, quo_reg[RW-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, dvs_reg};

    // signed quotient of the exact division
    assign q_x = neg_reg ? -{{(RW-W-1){1'b0}}, quo_reg[W:0]}
                         : {{(RW-W-1){1'b0}}, quo_reg[W:0]};

    // floor modulo correction, then back into the range
    assign fix     = (neg_reg && (rem_reg != '0)) ? (size - rem_reg) : rem_reg;
    assign wrapped = {{2{range_low_reg[W-1]}}, range_low_reg} + {1'b0, fix};

    assign in_take  = in_valid && (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg;
        exact_pass_next   = exact_pass_reg;
        cnt_next          = cnt_reg;
        held_next         = held_reg;
        range_low_next    = range_low_reg;
        range_high_next   = range_high_reg;
        mode_next         = mode_reg;
        operand_next      = operand_reg;
        commit_next       = commit_reg;
        prior_next        = prior_reg;
        raw_next          = raw_reg;
        neg_next          = neg_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        dvs_next          = dvs_reg;
        res_next          = res_reg;
        err_next          = err_reg;
        store_next        = store_reg;
        result_value_next = result_value_reg;
        prior_value_next  = prior_value_reg;
        error_code_next   = error_code_reg;

        // result register drains independently of the sequencer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // configuration, taken only while idle
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wrma_pkg::REG_RANGE_LOW:  range_low_next  = cfg_data;
                wrma_pkg::REG_RANGE_HIGH: range_high_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    mode_next    = mode;
                    operand_next = operand;
                    commit_next  = commit;
                    prior_next   = held_reg;
                    state_next   = S_SETUP;
                end
            end

            S_SETUP:
            begin
                // default outcome: report the held value, store nothing
                res_next        = prior_reg;
                err_next        = wrma_pkg::ERR_NONE;
                store_next      = 1'b0;
                exact_pass_next = 1'b0;
                state_next      = S_WRAP_LOAD;
                if (bad_range)
                begin
                    err_next   = wrma_pkg::ERR_BAD_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    case (mode_reg)
                        wrma_pkg::MODE_ASSIGN:  raw_next = op_x;
                        wrma_pkg::MODE_ADD:     raw_next = prior_x + op_x;
                        wrma_pkg::MODE_SUB:     raw_next = prior_x - op_x;
                        wrma_pkg::MODE_MUL:     raw_next = prod_x;
                        wrma_pkg::MODE_REFLECT: raw_next = high_x - prior_x;
                        wrma_pkg::MODE_DIV:
                        begin
                            if (operand_reg == '0)
                            begin
                                err_next   = wrma_pkg::ERR_DIV_ZERO;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                exact_pass_next = 1'b1;
                                neg_next        = prior_reg[W-1] ^ operand_reg[W-1];
                                rem_next        = '0;
                                quo_next        = {{(RW-W-1){1'b0}}, mag_prior};
                                dvs_next        = mag_op;
                                cnt_next        = STEP_W'(RW - 1);
                                state_next      = S_DIV;
                            end
                        end
                        default:
                        begin
                            // unused modes pass the held value through
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_WRAP_LOAD:
            begin
                exact_pass_next = 1'b0;
                neg_next        = diff[RW];
                rem_next        = '0;
                quo_next        = mag_diff[RW-1:0];
                dvs_next        = size;
                cnt_next        = STEP_W'(RW - 1);
                state_next      = S_DIV;
            end

            S_DIV:
            begin
                if (!div_trial[W+2])
                begin
                    rem_next = div_trial[W:0];
                end
                else
                begin
                    rem_next = div_shift[W:0];
                end
                quo_next = {quo_reg[RW-2:0], ~div_trial[W+2]};
                cnt_next = cnt_reg - STEP_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_POST;
                end
            end

            S_POST:
            begin
                if (exact_pass_reg)
                begin
                    if (rem_reg != '0)
                    begin
                        err_next   = wrma_pkg::ERR_INEXACT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        raw_next   = q_x;
                        state_next = S_WRAP_LOAD;
                    end
                end
                else
                begin
                    res_next   = wrapped[W-1:0];
                    store_next = commit_reg;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next    = 1'b1;
                    result_value_next = res_reg;
                    prior_value_next  = prior_reg;
                    error_code_next   = err_reg;
                    if (store_reg)
                    begin
                        held_next = res_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            exact_pass_reg <= 1'b0;
            cnt_reg        <= '0;
            held_reg       <= W'(wrma_pkg::RANGE_LOW_RESET);
            range_low_reg  <= W'(wrma_pkg::RANGE_LOW_RESET);
            range_high_reg <= W'(wrma_pkg::RANGE_HIGH_RESET);
            store_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            exact_pass_reg <= exact_pass_next;
            cnt_reg        <= cnt_next;
            held_reg       <= held_next;
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
            store_reg      <= store_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg         <= mode_next;
        operand_reg      <= operand_next;
        commit_reg       <= commit_next;
        prior_reg        <= prior_next;
        raw_reg          <= raw_next;
        neg_reg          <= neg_next;
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        dvs_reg          <= dvs_next;
        res_reg          <= res_next;
        err_reg          <= err_next;
        result_value_reg <= result_value_next;
        prior_value_reg  <= prior_value_next;
        error_code_reg   <= error_code_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign prior_value  = prior_value_reg;
    assign error_code   = error_code_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // a word in flight closes the input until it is finished
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open right after a word was taken");

    // on any error the reported value is the held value
    a_error_keeps_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (error_code != wrma_pkg::ERR_NONE))
            |-> (result_value == prior_value))
        else $error("error word reports a changed value");

    // the held value moves only when a finished word is handed out
    a_held_moves_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg != $past(held_reg)) |-> $past(state_reg == S_DONE))
        else $error("held value changed outside word completion");

    // a new result appears only out of the done state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside completion");

endmodule
